@@ src/cbm_pkg.sv @@
// Shared types and constants for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

  typedef enum logic [1:0] {
    KIND_HIGH_WRITE = 2'd0,
    KIND_LOW_WRITE  = 2'd1,
    KIND_TICK       = 2'd2,
    KIND_RESET      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_PRG_BANK_COUNT = 2'd0,
    CFG_CHR_BANK_COUNT = 2'd1,
    CFG_FOUR_SCREEN    = 2'd2
  } cfg_index_t;

  typedef logic [3:0][7:0] prg_banks_t;
  typedef logic [7:0][7:0] chr_banks_t;
  typedef logic [5:0][7:0] chr_sel_t;
  typedef logic [1:0][7:0] sel_pair_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
    logic        render_enabled;
  } item_t;

  typedef struct packed {
    logic [31:0] prg_slots;
    logic [63:0] chr_slots;
    logic        mirror_horizontal;
    logic        irq_pulse;
  } result_t;

  typedef struct packed {
    logic [8:0] prg_bank_count;
    logic [8:0] chr_bank_count;
    logic       four_screen;
  } cfg_t;

  // Register addresses on the CPU bus.
  localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
  localparam logic [15:0] ADDR_EXT_ENABLE  = 16'h8003;
  localparam logic [15:0] ADDR_MIRROR      = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_COUNT   = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF_A   = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON_A    = 16'hE001;
  localparam logic [15:0] ADDR_IRQ_OFF_B   = 16'hE002;
  localparam logic [15:0] ADDR_IRQ_ON_B    = 16'hE003;
  localparam logic [15:0] ADDR_EXT_MODE    = 16'h5000;

  localparam logic [7:0] CTRL_FORCE_SLOT1  = 8'h2A;
  localparam logic [7:0] CTRL_FORCE_SLOT2  = 8'h28;
  localparam logic [7:0] FORCED_BANK1      = 8'h0F;
  localparam logic [7:0] FORCED_BANK2      = 8'h17;
  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  localparam logic [8:0] PRG_COUNT_RESET = 9'd16;
  localparam logic [8:0] CHR_COUNT_RESET = 9'd128;

  localparam chr_sel_t CHR_SEL_INIT = {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

endpackage

`default_nettype wire

@@ src/cbm_in_reg.sv @@
// Input register holding one accepted transaction until the core takes it.
`default_nettype none

module cbm_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cbm_pkg::item_t item_in,
  input  wire logic          take,
  output logic               held_valid,
  output cbm_pkg::item_t     held_item
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= item_in;
    end
  end

endmodule

`default_nettype wire

@@ src/cbm_cfg_regs.sv @@
// Configuration registers written through the plain write port.
`default_nettype none

module cbm_cfg_regs (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_enable,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  output cbm_pkg::cfg_t   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_bank_count <= cbm_pkg::PRG_COUNT_RESET;
      cfg.chr_bank_count <= cbm_pkg::CHR_COUNT_RESET;
      cfg.four_screen    <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cbm_pkg::cfg_index_t'(cfg_index))
        cbm_pkg::CFG_PRG_BANK_COUNT: cfg.prg_bank_count <= cfg_data;
        cbm_pkg::CFG_CHR_BANK_COUNT: cfg.chr_bank_count <= cfg_data;
        cbm_pkg::CFG_FOUR_SCREEN:    cfg.four_screen    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/cbm_core.sv @@
// Mapper state and its update for one transaction.
`default_nettype none

module cbm_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire cbm_pkg::item_t item,
  input  wire cbm_pkg::cfg_t  cfg,
  output cbm_pkg::result_t    result
);

  localparam logic [8:0] PRG_LBO_RESET_W  = cbm_pkg::PRG_COUNT_RESET - 9'd2;
  localparam logic [8:0] PRG_LAST_RESET_W = cbm_pkg::PRG_COUNT_RESET - 9'd1;
  localparam logic [7:0] PRG_LBO_RESET    = PRG_LBO_RESET_W[7:0];
  localparam logic [7:0] PRG_LAST_RESET   = PRG_LAST_RESET_W[7:0];

  logic [7:0]          bank_control, bank_control_next;
  logic                extended_enable, extended_enable_next;
  logic [7:0]          extended_mode, extended_mode_next;
  cbm_pkg::sel_pair_t  prg_select, prg_select_next;
  cbm_pkg::sel_pair_t  ext_prg_select, ext_prg_select_next;
  cbm_pkg::chr_sel_t   chr_select, chr_select_next;
  cbm_pkg::prg_banks_t prg_slot, prg_slot_next;
  cbm_pkg::chr_banks_t chr_slot, chr_slot_next;
  logic                mirror_mode, mirror_mode_next;
  logic                irq_enable, irq_enable_next;
  logic [7:0]          irq_count, irq_count_next;
  logic [7:0]          irq_reload, irq_reload_next;
  logic                pulse;

  logic [7:0] last_but_one;
  logic [7:0] last_bank;
  logic       has_chr;
  logic [2:0] which;
  logic [7:0] low_base;

  function automatic cbm_pkg::chr_banks_t refresh_chr(input logic [7:0] ctrl,
                                                      input cbm_pkg::chr_sel_t sel);
    logic [3:0][7:0]     lo;
    logic [3:0][7:0]     hi;
    cbm_pkg::chr_banks_t r;
    lo = {sel[1] + 8'd1, sel[1], sel[0] + 8'd1, sel[0]};
    hi = {sel[5], sel[4], sel[3], sel[2]};
    if (ctrl[7]) begin
      r = {lo, hi};
    end else begin
      r = {hi, lo};
    end
    return r;
  endfunction

  function automatic cbm_pkg::prg_banks_t refresh_prg(input logic [7:0] ctrl,
                                                      input cbm_pkg::sel_pair_t sel,
                                                      input logic [7:0] lbo,
                                                      input logic [7:0] lb);
    cbm_pkg::prg_banks_t r;
    if (ctrl[6]) begin
      r = {lb, sel[0], sel[1], lbo};
    end else begin
      r = {lb, lbo, sel[1], sel[0]};
    end
    return r;
  endfunction

  assign last_but_one = cfg.prg_bank_count[7:0] - 8'd2;
  assign last_bank    = cfg.prg_bank_count[7:0] - 8'd1;
  assign has_chr      = (cfg.chr_bank_count != 9'd0);
  assign which        = bank_control[2:0];

  always_comb begin
    bank_control_next    = bank_control;
    extended_enable_next = extended_enable;
    extended_mode_next   = extended_mode;
    prg_select_next      = prg_select;
    ext_prg_select_next  = ext_prg_select;
    chr_select_next      = chr_select;
    prg_slot_next        = prg_slot;
    chr_slot_next        = chr_slot;
    mirror_mode_next     = mirror_mode;
    irq_enable_next      = irq_enable;
    irq_count_next       = irq_count;
    irq_reload_next      = irq_reload;
    pulse                = 1'b0;
    low_base             = 8'd0;

    if (take) begin
      unique case (item.kind)
        cbm_pkg::KIND_HIGH_WRITE: begin
          unique case (item.address)
            cbm_pkg::ADDR_BANK_SELECT: begin
              extended_enable_next = 1'b0;
              bank_control_next    = item.write_data;
              if (has_chr) begin
                chr_slot_next = refresh_chr(item.write_data, chr_select);
              end
            end
            cbm_pkg::ADDR_BANK_DATA: begin
              if (extended_enable) begin
                if (bank_control == cbm_pkg::CTRL_FORCE_SLOT1) begin
                  prg_slot_next[1] = cbm_pkg::FORCED_BANK1;
                end
                if (bank_control == cbm_pkg::CTRL_FORCE_SLOT2) begin
                  prg_slot_next[2] = cbm_pkg::FORCED_BANK2;
                end
              end else if (which <= 3'd5) begin
                if (has_chr) begin
                  chr_select_next[which] = (which <= 3'd1) ?
                                           {item.write_data[7:1], 1'b0} : item.write_data;
                  chr_slot_next = refresh_chr(bank_control, chr_select_next);
                end
              end else begin
                // Extended mode with bits 7 and 5 set locks the normal PRG selects.
                if (!(extended_mode[7] && extended_mode[5])) begin
                  prg_select_next[which[0]] = item.write_data;
                  prg_slot_next = refresh_prg(bank_control, prg_select_next,
                                              last_but_one, last_bank);
                end
                ext_prg_select_next[which[0]] = item.write_data;
              end
            end
            cbm_pkg::ADDR_EXT_ENABLE: begin
              extended_enable_next = 1'b1;
              if (item.write_data[7:4] == 4'd0) begin
                prg_slot_next[2] = last_but_one;
              end
            end
            cbm_pkg::ADDR_MIRROR: begin
              if (!cfg.four_screen) begin
                mirror_mode_next = item.write_data[0];
              end
            end
            cbm_pkg::ADDR_IRQ_COUNT:  irq_count_next  = item.write_data;
            cbm_pkg::ADDR_IRQ_RELOAD: irq_reload_next = item.write_data;
            cbm_pkg::ADDR_IRQ_OFF_A,
            cbm_pkg::ADDR_IRQ_OFF_B:  irq_enable_next = 1'b0;
            cbm_pkg::ADDR_IRQ_ON_A,
            cbm_pkg::ADDR_IRQ_ON_B:   irq_enable_next = 1'b1;
            default: ;
          endcase
        end
        cbm_pkg::KIND_LOW_WRITE: begin
          if (item.address == cbm_pkg::ADDR_EXT_MODE) begin
            if (item.write_data[7]) begin
              if (item.write_data[5]) begin
                // 32 KiB mode: four consecutive banks from an even 16 KiB pair.
                low_base = {2'b00, item.write_data[4:1], 2'b00};
                prg_slot_next = {low_base + 8'd3, low_base + 8'd2,
                                 low_base + 8'd1, low_base};
              end else begin
                low_base = {2'b00, item.write_data[4:0], 1'b0};
                prg_slot_next[1] = low_base;
                prg_slot_next[2] = low_base + 8'd1;
              end
            end else begin
              prg_slot_next = {last_bank, last_but_one,
                               ext_prg_select[1], ext_prg_select[0]};
            end
            extended_mode_next = item.write_data;
          end
        end
        cbm_pkg::KIND_TICK: begin
          if (irq_enable && item.render_enabled &&
              item.scanline <= cbm_pkg::LAST_VISIBLE_LINE) begin
            if (irq_count == 8'd0) begin
              irq_count_next = irq_reload;
              pulse          = 1'b1;
            end else begin
              irq_count_next = irq_count - 8'd1;
            end
          end
        end
        cbm_pkg::KIND_RESET: begin
          bank_control_next = 8'd0;
          prg_select_next   = {8'd1, 8'd0};
          if (has_chr) begin
            chr_select_next = cbm_pkg::CHR_SEL_INIT;
            chr_slot_next   = refresh_chr(8'd0, cbm_pkg::CHR_SEL_INIT);
          end else begin
            chr_select_next = '0;
          end
          ext_prg_select_next  = {8'd1, 8'd0};
          extended_enable_next = 1'b0;
          extended_mode_next   = 8'd0;
          prg_slot_next        = refresh_prg(8'd0, {8'd1, 8'd0}, last_but_one, last_bank);
          irq_enable_next      = 1'b0;
          irq_count_next       = 8'd0;
          irq_reload_next      = 8'd0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.prg_slots         = prg_slot_next;
    result.chr_slots         = chr_slot_next;
    result.mirror_horizontal = mirror_mode_next;
    result.irq_pulse         = pulse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_control    <= 8'd0;
      extended_enable <= 1'b0;
      extended_mode   <= 8'd0;
      prg_select      <= {8'd1, 8'd0};
      ext_prg_select  <= {8'd1, 8'd0};
      chr_select      <= cbm_pkg::CHR_SEL_INIT;
      prg_slot        <= {PRG_LAST_RESET, PRG_LBO_RESET, 8'd1, 8'd0};
      chr_slot        <= {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};
      mirror_mode     <= 1'b0;
      irq_enable      <= 1'b0;
      irq_count       <= 8'd0;
      irq_reload      <= 8'd0;
    end else begin
      bank_control    <= bank_control_next;
      extended_enable <= extended_enable_next;
      extended_mode   <= extended_mode_next;
      prg_select      <= prg_select_next;
      ext_prg_select  <= ext_prg_select_next;
      chr_select      <= chr_select_next;
      prg_slot        <= prg_slot_next;
      chr_slot        <= chr_slot_next;
      mirror_mode     <= mirror_mode_next;
      irq_enable      <= irq_enable_next;
      irq_count       <= irq_count_next;
      irq_reload      <= irq_reload_next;
    end
  end

endmodule

`default_nettype wire

@@ src/cbm_out_reg.sv @@
// Result register that holds one transaction until the consumer takes it.
`default_nettype none

module cbm_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire cbm_pkg::result_t result_in,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cbm_pkg::result_t      result_q
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

`default_nettype wire

@@ src/cartridge_bank_mapper_with_scanline_irq.sv @@
// Top level of the cartridge bank mapper with scanline interrupt counter.
`default_nettype none

// A bank mapper for a game cartridge in the style of an extended MMC3. Each
// input transaction is a CPU write to the 0x8000-0xFFFF register space, a
// write to the extended mode register at 0x5000, a scanline tick, or a mapper
// reset, chosen by kind. For every input transaction exactly one result
// transaction follows, carrying the four 8 KiB PRG slot banks, the eight
// 1 KiB CHR slot banks, the mirroring and a one-transaction interrupt pulse,
// all as they stand after that input. Bank numbers are raw 8-bit values;
// masking to the ROM size is up to the consumer. The block takes one
// transaction per clock cycle while the output is not stalled. An accepted
// input is held in the input register; the mapper state updates and the
// result register loads from it together, once the result register is free.
// Stalls on the output hold the input register and then drop in_ready, so
// nothing is lost. The configuration registers (PRG bank count, CHR bank
// count, four-screen flag) must be written only while the block is idle;
// the block itself does not enforce this. They take effect at the next bank
// refresh or mirroring write, not immediately.
module cartridge_bank_mapper_with_scanline_irq (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_write_enable,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic [8:0]  scanline,
  input  wire logic        render_enabled,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      prg_slots,
  output logic [63:0]      chr_slots,
  output logic             mirror_horizontal,
  output logic             irq_pulse
);

  cbm_pkg::item_t   item_in;
  cbm_pkg::item_t   held_item;
  cbm_pkg::cfg_t    cfg;
  cbm_pkg::result_t core_result;
  cbm_pkg::result_t result_q;
  logic             held_valid;
  logic             out_free;
  logic             take;

  assign item_in.kind           = cbm_pkg::kind_t'(kind);
  assign item_in.address        = address;
  assign item_in.write_data     = write_data;
  assign item_in.scanline       = scanline;
  assign item_in.render_enabled = render_enabled;

  // The held transaction is processed in the cycle the result register can
  // take its result, so state updates and results stay in lockstep.
  assign take = held_valid && out_free;

  cbm_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item_in   (item_in),
    .take      (take),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  cbm_cfg_regs u_cfg_regs (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cfg             (cfg)
  );

  cbm_core u_core (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (held_item),
    .cfg   (cfg),
    .result(core_result)
  );

  cbm_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .result_in(core_result),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_q (result_q)
  );

  assign prg_slots         = result_q.prg_slots;
  assign chr_slots         = result_q.chr_slots;
  assign mirror_horizontal = result_q.mirror_horizontal;
  assign irq_pulse         = result_q.irq_pulse;

  // Input backpressure only happens when both stages are full and stalled.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (held_valid && out_valid && !out_ready))
    else $error("in_ready low without a full, stalled pipeline");

  // A processed transaction always shows up in the result register next cycle.
  assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("processed transaction did not reach the result register");

  // A held transaction that is not processed must stay put.
  assert property (@(posedge clk) disable iff (rst)
    (held_valid && !take) |=> (held_valid && $stable(held_item)))
    else $error("held transaction changed or vanished before processing");

  // Only scanline ticks can raise the interrupt pulse.
  assert property (@(posedge clk) disable iff (rst)
    (take && core_result.irq_pulse) |-> (held_item.kind == cbm_pkg::KIND_TICK))
    else $error("interrupt pulse from a transaction that is not a tick");

endmodule

`default_nettype wire
